@@ hw/rtl/mcpwm_pkg.sv @@
package mcpwm_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int PERIOD       = 256;

    localparam int ACT_W  = 3;
    localparam int CH_W   = 4;
    localparam int DUTY_W = 9;
    localparam int MASK_W = 8;
    localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W  = $clog2(PERIOD);
    localparam int CMP_W  = (CNT_W > DUTY_W) ? CNT_W : DUTY_W;
    localparam int NCNT_W = $clog2(NUM_CHANNELS + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_SET    = 3'd3,
        ACT_GET    = 3'd4
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } dp_cmd_t;

    typedef struct packed {
        logic out_room;
    } dp_stat_t;

endpackage

@@ hw/rtl/multichannel_pwm_with_slot_allocation_top.sv @@
// Eight-channel PWM with a shared 8-bit period counter and a slot table.
// Each input beat carries one action (tick, insert, delete, set duty, get
// duty) and yields exactly one result beat holding status, the granted
// slot, the duty read back, the channel levels and the allocation mask.
// An item is captured first and then executed in the datapath, where all
// channel compares on a tick run in parallel. The execute state waits
// while the previous result is still stalled in the output register, and
// a new item is accepted only once the current one has executed.
module multichannel_pwm_with_slot_allocation_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mcpwm_pkg::ACT_W-1:0]        action,
    input  logic [mcpwm_pkg::CH_W-1:0]         channel,
    input  logic [mcpwm_pkg::DUTY_W-1:0]       duty,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               status,
    output logic [mcpwm_pkg::CH_W-1:0]         new_channel,
    output logic [mcpwm_pkg::DUTY_W-1:0]       duty_read,
    output logic [mcpwm_pkg::MASK_W-1:0]       levels,
    output logic [mcpwm_pkg::MASK_W-1:0]       active_mask
);
    import mcpwm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mcpwm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mcpwm_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .channel     (channel),
        .duty        (duty),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .new_channel (new_channel),
        .duty_read   (duty_read),
        .levels      (levels),
        .active_mask (active_mask)
    );

endmodule

@@ hw/rtl/mcpwm_ctrl.sv @@
module mcpwm_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mcpwm_pkg::dp_stat_t stat,
    output mcpwm_pkg::dp_cmd_t  cmd
);
    import mcpwm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_stall    = 1'b1;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result register can take a new beat
                if (stat.out_room)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/mcpwm_dp.sv @@
module mcpwm_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  mcpwm_pkg::dp_cmd_t                 cmd,
    output mcpwm_pkg::dp_stat_t                stat,
    input  logic [mcpwm_pkg::ACT_W-1:0]        action,
    input  logic [mcpwm_pkg::CH_W-1:0]         channel,
    input  logic [mcpwm_pkg::DUTY_W-1:0]       duty,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               status,
    output logic [mcpwm_pkg::CH_W-1:0]         new_channel,
    output logic [mcpwm_pkg::DUTY_W-1:0]       duty_read,
    output logic [mcpwm_pkg::MASK_W-1:0]       levels,
    output logic [mcpwm_pkg::MASK_W-1:0]       active_mask
);
    import mcpwm_pkg::*;

    // captured item
    logic [ACT_W-1:0]  act_reg;
    logic [CH_W-1:0]   chan_reg;
    logic [DUTY_W-1:0] duty_in_reg;

    // block state
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DUTY_W-1:0]       duty_tab_reg [NUM_CHANNELS];
    logic [DUTY_W-1:0]       duty_tab_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] active_reg, active_next;
    logic [NCNT_W-1:0]       count_reg, count_next;
    logic [NUM_CHANNELS-1:0] level_reg, level_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              status_reg, status_next;
    logic [CH_W-1:0]   new_ch_reg, new_ch_next;
    logic [DUTY_W-1:0] duty_rd_reg, duty_rd_next;

    logic [CH_W-1:0]   chan_m1;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic [SLOT_W-1:0] free_idx;
    logic              free_found;

    assign stat.out_room = !out_valid_reg || !out_stall;

    assign chan_m1 = chan_reg - CH_W'(1);
    assign slot    = chan_m1[SLOT_W-1:0];
    assign hit     = (chan_reg != '0) && (chan_reg <= CH_W'(NUM_CHANNELS)) && active_reg[slot];

    // lowest free slot
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_idx   = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        duty_tab_next  = duty_tab_reg;
        active_next    = active_reg;
        count_next     = count_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        new_ch_next    = new_ch_reg;
        duty_rd_next   = duty_rd_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
            status_next    = 1'b0;
            new_ch_next    = '0;
            duty_rd_next   = '0;
            case (act_reg)
                ACT_TICK:
                begin
                    if (cnt_reg == CNT_W'(PERIOD - 1))
                    begin
                        cnt_next = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        level_next[i] = active_reg[i] &&
                                        (CMP_W'(cnt_next) < CMP_W'(duty_tab_reg[i]));
                    end
                end
                ACT_INSERT:
                begin
                    if ((count_reg < NCNT_W'(NUM_CHANNELS)) && free_found)
                    begin
                        active_next[free_idx]   = 1'b1;
                        duty_tab_next[free_idx] = '0;
                        count_next              = count_reg + NCNT_W'(1);
                        new_ch_next             = CH_W'(free_idx) + CH_W'(1);
                    end
                end
                ACT_DELETE:
                begin
                    if (hit)
                    begin
                        active_next[slot]   = 1'b0;
                        duty_tab_next[slot] = '0;
                        level_next[slot]    = 1'b0;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - NCNT_W'(1);
                        end
                    end
                    else
                    begin
                        status_next = 1'b1;
                    end
                end
                ACT_SET:
                begin
                    if (hit)
                    begin
                        duty_tab_next[slot] = duty_in_reg;
                    end
                    else
                    begin
                        status_next = 1'b1;
                    end
                end
                ACT_GET:
                begin
                    if (hit)
                    begin
                        duty_rd_next = duty_tab_reg[slot];
                    end
                    else
                    begin
                        status_next = 1'b1;
                    end
                end
                default:
                begin
                    // unknown action: leave state alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            active_reg    <= '0;
            count_reg     <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            active_reg    <= active_next;
            count_reg     <= count_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a free slot's duty is never observed before insert clears it
    always_ff @(posedge clk)
    begin
        duty_tab_reg <= duty_tab_next;
        status_reg   <= status_next;
        new_ch_reg   <= new_ch_next;
        duty_rd_reg  <= duty_rd_next;
        if (cmd.capture)
        begin
            act_reg     <= action;
            chan_reg    <= channel;
            duty_in_reg <= duty;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign new_channel = new_ch_reg;
    assign duty_read   = duty_rd_reg;
    assign levels      = MASK_W'(level_reg);
    assign active_mask = MASK_W'(active_reg);

endmodule

@@ hw/rtl/mcpwm_checker.sv @@
module mcpwm_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic                               status,
    input logic [mcpwm_pkg::CH_W-1:0]         new_channel,
    input logic [mcpwm_pkg::DUTY_W-1:0]       duty_read,
    input logic [mcpwm_pkg::MASK_W-1:0]       levels,
    input logic [mcpwm_pkg::MASK_W-1:0]       active_mask
);
    import mcpwm_pkg::*;

    // one item in flight: an accepted beat stalls the input in the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while previous item still executing");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(levels) && $stable(active_mask)
                                   && $stable(status) && $stable(duty_read))
        else $error("stalled result beat changed");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> new_channel == '0 && duty_read == '0)
        else $error("error result carries data");

    a_grant_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_channel != '0 |-> !status && duty_read == '0
                                            && active_mask != '0)
        else $error("granted slot with inconsistent result");

    a_level_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (levels & ~active_mask) == '0)
        else $error("free channel driven high");

endmodule

bind multichannel_pwm_with_slot_allocation_top mcpwm_checker u_mcpwm_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .new_channel (new_channel),
    .duty_read   (duty_read),
    .levels      (levels),
    .active_mask (active_mask)
);

@@ tb/multichannel_pwm_with_slot_allocation_top_test.sv @@
`timescale 1ns / 100ps

module multichannel_pwm_with_slot_allocation_top_test;

    import mcpwm_pkg::*;

    localparam int ACT_LAST   = (1 << ACT_W) - 1;
    localparam int CH_LAST    = (1 << CH_W) - 1;
    localparam int N_ITEMS    = 1300;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic              status;
        logic [CH_W-1:0]   new_channel;
        logic [DUTY_W-1:0] duty_read;
        logic [MASK_W-1:0] levels;
        logic [MASK_W-1:0] active_mask;
    } pwm_result_t;

    class pwm_scoreboard;
        int unsigned             counter;
        logic [DUTY_W-1:0]       duty_tab [NUM_CHANNELS];
        logic [NUM_CHANNELS-1:0] alloc;
        int unsigned             n_alloc;
        logic [MASK_W-1:0]       lvl;
        pwm_result_t             awaited_results [$];
        int                      errors;

        function new();
            counter = 0;
            alloc   = '0;
            n_alloc = 0;
            lvl     = '0;
            errors  = 0;
            foreach (duty_tab[i])
                duty_tab[i] = '0;
        endfunction

        function automatic bit is_live(logic [CH_W-1:0] ch);
            return ch != 0 && ch <= NUM_CHANNELS && alloc[ch - 1];
        endfunction

        // Advance the model by one beat and queue the result it must produce.
        function void note_input(logic [ACT_W-1:0] act, logic [CH_W-1:0] ch,
                                 logic [DUTY_W-1:0] d);
            pwm_result_t r;
            r = '0;
            case (act)
                ACT_TICK:
                begin
                    counter = (counter + 1) % PERIOD;
                    lvl = '0;
                    for (int i = 0; i < NUM_CHANNELS && i < MASK_W; i++)
                        if (alloc[i] && counter < duty_tab[i])
                            lvl[i] = 1'b1;
                end
                ACT_INSERT:
                begin
                    if (n_alloc < NUM_CHANNELS)
                    begin
                        for (int i = 0; i < NUM_CHANNELS; i++)
                        begin
                            if (!alloc[i])
                            begin
                                alloc[i]      = 1'b1;
                                duty_tab[i]   = '0;
                                n_alloc++;
                                r.new_channel = CH_W'(i + 1);
                                break;
                            end
                        end
                    end
                end
                ACT_DELETE:
                begin
                    if (is_live(ch))
                    begin
                        alloc[ch - 1]    = 1'b0;
                        duty_tab[ch - 1] = '0;
                        if (ch - 1 < MASK_W)
                            lvl[ch - 1] = 1'b0;
                        if (n_alloc > 0)
                            n_alloc--;
                    end
                    else
                        r.status = 1'b1;
                end
                ACT_SET:
                begin
                    if (is_live(ch))
                        duty_tab[ch - 1] = d;
                    else
                        r.status = 1'b1;
                end
                ACT_GET:
                begin
                    if (is_live(ch))
                        r.duty_read = duty_tab[ch - 1];
                    else
                        r.status = 1'b1;
                end
                default:
                    ;
            endcase
            r.levels      = lvl;
            r.active_mask = MASK_W'(alloc);
            awaited_results.push_back(r);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(pwm_result_t got);
            pwm_result_t want;
            if (awaited_results.size() == 0)
            begin
                report("result beat with nothing outstanding");
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.new_channel !== want.new_channel)
                report($sformatf("new_channel %0d, want %0d",
                                 got.new_channel, want.new_channel));
            if (got.duty_read !== want.duty_read)
                report($sformatf("duty_read %0d, want %0d",
                                 got.duty_read, want.duty_read));
            if (got.levels !== want.levels)
                report($sformatf("levels %h, want %h", got.levels, want.levels));
            if (got.active_mask !== want.active_mask)
                report($sformatf("active_mask %h, want %h",
                                 got.active_mask, want.active_mask));
        endtask
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [ACT_W-1:0]  action    = '0;
    logic [CH_W-1:0]   channel   = '0;
    logic [DUTY_W-1:0] duty      = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              status;
    logic [CH_W-1:0]   new_channel;
    logic [DUTY_W-1:0] duty_read;
    logic [MASK_W-1:0] levels;
    logic [MASK_W-1:0] active_mask;

    logic [15:0]       stall_pat = '0;
    logic [15:0]       rx_cyc    = '0;

    pwm_scoreboard sb = new();

    multichannel_pwm_with_slot_allocation_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .channel     (channel),
        .duty        (duty),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .new_channel (new_channel),
        .duty_read   (duty_read),
        .levels      (levels),
        .active_mask (active_mask)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Present one beat and hold it until the block takes it.
    task automatic send_item(input logic [ACT_W-1:0] a, input logic [CH_W-1:0] c,
                             input logic [DUTY_W-1:0] d);
        in_valid <= 1'b1;
        action   <= a;
        channel  <= c;
        duty     <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(a, c, d);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Pick a random beat, mostly well-formed against the current slot table.
    task automatic send_random();
        logic [ACT_W-1:0]  a;
        logic [CH_W-1:0]   c;
        logic [DUTY_W-1:0] d;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            a = ACT_TICK;
        else if (pick < 56)
            a = ACT_INSERT;
        else if (pick < 66)
            a = ACT_DELETE;
        else if (pick < 84)
            a = ACT_SET;
        else if (pick < 97)
            a = ACT_GET;
        else
            a = ACT_W'($urandom_range(ACT_GET + 1, ACT_LAST));
        pick = $urandom_range(0, 9);
        if (pick < 6 && sb.alloc != 0)
        begin
            do
                c = CH_W'($urandom_range(1, NUM_CHANNELS));
            while (!sb.alloc[c - 1]);
        end
        else if (pick < 8)
            c = CH_W'($urandom_range(1, NUM_CHANNELS));
        else
            c = CH_W'($urandom_range(0, CH_LAST));
        case ($urandom_range(0, 9))
            0:       d = DUTY_W'($urandom);
            1:       d = DUTY_W'(PERIOD);
            2, 3:    d = DUTY_W'(sb.counter + $urandom_range(0, 3));
            default: d = DUTY_W'($urandom_range(0, PERIOD));
        endcase
        send_item(a, c, d);
    endtask

    // Receiver: take results, stall on a pattern that changes when rx_cyc[6:0] wraps to zero.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({status, new_channel, duty_read, levels, active_mask});
        rx_cyc <= rx_cyc + 1'b1;
        if (rx_cyc[6:0] == 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_pat <= '0;
                1:       stall_pat <= 16'($urandom & $urandom) & 16'hFFFE;
                2:       stall_pat <= 16'($urandom) & 16'hFFFE;
                default: stall_pat <= 16'h7FFE;
            endcase
        end
        out_stall <= stall_pat[rx_cyc[3:0]];
    end

    initial
    begin
        int n_sent;
        int burst;
        n_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(ACT_TICK, 4'd0, 9'd0);
        send_item(ACT_GET, 4'd1, 9'd0);
        // fill the table, then one insert too many
        repeat (NUM_CHANNELS + 1)
            send_item(ACT_INSERT, 4'd0, 9'd0);
        send_item(ACT_SET, 4'd1, DUTY_W'(PERIOD));
        send_item(ACT_SET, 4'd2, '1);
        send_item(ACT_SET, 4'd3, 9'd1);
        send_item(ACT_SET, CH_W'(NUM_CHANNELS), 9'd0);
        send_item(ACT_SET, 4'd0, 9'd100);
        send_item(ACT_SET, '1, '1);
        send_item(ACT_GET, CH_W'(NUM_CHANNELS + 1), 9'd0);
        send_item(ACT_TICK, '1, '1);
        send_item(ACT_GET, 4'd2, 9'd0);
        // high channel drops low on delete
        send_item(ACT_DELETE, 4'd1, 9'd0);
        send_item(ACT_DELETE, 4'd1, 9'd0);
        for (int k = ACT_GET + 1; k <= ACT_LAST; k++)
            send_item(ACT_W'(k), '1, '1);
        send_item(ACT_INSERT, '1, '1);
        idle_gap(3);

        while (n_sent < N_ITEMS)
        begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 16);
            for (int i = 0; i < burst && n_sent < N_ITEMS; i++)
            begin
                send_random();
                n_sent++;
            end
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
        end
        in_valid <= 1'b0;

        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.errors == 0 && sb.awaited_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
